// ----- sv/gcdt_pkg.sv -----
// ----------------------------------------------------------------------------
// gcdt_pkg
// Shared types and constants of the grid chamfer distance transform.
// ----------------------------------------------------------------------------
package gcdt_pkg;

  localparam int unsigned DIST_W   = 16;
  localparam int unsigned DIM_W    = 7;
  localparam int unsigned CELL_W   = 12;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  localparam logic [DIST_W-1:0] DIST_INF  = '1;
  localparam logic [DIST_W-1:0] DIST_ZERO = '0;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_STRAIGHT_STEP,
    REG_DIAGONAL_STEP
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CELL_RD,
    ST_CELL_VERT,
    ST_CELL_SIDE,
    ST_CELL_DIAG,
    ST_DONE
  } state_e;

endpackage

// ----- sv/gcdt_relax.sv -----
// ----------------------------------------------------------------------------
// gcdt_relax
// Shared relaxation unit: saturating neighbor-plus-step, then minimum.
// ----------------------------------------------------------------------------
module gcdt_relax
  import gcdt_pkg::*;
(
  input  logic              en_i,
  input  logic [DIST_W-1:0] cur_i,
  input  logic [DIST_W-1:0] nbr_i,
  input  logic [DIST_W-1:0] step_i,
  output logic [DIST_W-1:0] dist_o
);

  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] sat;

  assign sum    = {1'b0, nbr_i} + {1'b0, step_i};
  assign sat    = sum[DIST_W] ? DIST_INF : sum[DIST_W-1:0];
  assign dist_o = (en_i && (sat < cur_i)) ? sat : cur_i;

endmodule

// ----- sv/grid_chamfer_distance_transform.sv -----
// ----------------------------------------------------------------------------
// grid_chamfer_distance_transform
// Occupancy grid store with a two-pass chamfer distance transform.
// ----------------------------------------------------------------------------
// A load beat gives no result; a read beat returns one result through the
// output register after a registered store read. A load beat marked last
// starts the transform: a forward and a backward raster pass over the w x h
// cells in use, each cell going through ST_CELL_RD for the two registered
// store reads, then ST_CELL_VERT, ST_CELL_SIDE and ST_CELL_DIAG, in which the
// single saturating add/compare unit relaxes the cell against its straight,
// side and diagonal neighbors; ST_DONE then gives the done result.
// The input stalls while a read or the transform is in progress.
module grid_chamfer_distance_transform
  import gcdt_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,

  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_mode_i,
  input  logic [CELL_W-1:0] in_cell_address_i,
  input  logic              in_occupied_i,
  input  logic              in_last_cell_i,

  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DIST_W-1:0] out_distance_o,
  output logic              out_transform_done_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [DIM_W-1:0]  grid_width_q, grid_height_q;
  logic [DIST_W-1:0] straight_step_q, diagonal_step_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q    <= DIM_W'(64);
      grid_height_q   <= DIM_W'(64);
      straight_step_q <= DIST_W'(26);
      diagonal_step_q <= DIST_W'(36);
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_GRID_WIDTH:    grid_width_q    <= pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT:   grid_height_q   <= pwdata[DIM_W-1:0];
        REG_STRAIGHT_STEP: straight_step_q <= pwdata[DIST_W-1:0];
        REG_DIAGONAL_STEP: diagonal_step_q <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_GRID_WIDTH:    prdata = APB_DW'(grid_width_q);
      REG_GRID_HEIGHT:   prdata = APB_DW'(grid_height_q);
      REG_STRAIGHT_STEP: prdata = APB_DW'(straight_step_q);
      REG_DIAGONAL_STEP: prdata = APB_DW'(diagonal_step_q);
      default:           prdata = '0;
    endcase
  end

  // effective grid size
  logic [DIM_W-1:0] w_eff, h_eff;

  always_comb begin
    if (grid_width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(grid_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width_q;
    end
    if (grid_height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(grid_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height_q;
    end
  end

  // sequencer and datapath state
  state_e            state_q, state_d;
  logic [AW-1:0]     k_q, k_d;
  logic [DIM_W-1:0]  row_q, row_d, col_q, col_d;
  logic              bwd_q, bwd_d;
  logic              rd_ok_q, rd_ok_d;
  logic [DIST_W-1:0] cur_q, cur_d, side_q, side_d, diag_q, diag_d, vert_q, vert_d;
  logic              out_valid_q, out_valid_d;
  logic [DIST_W-1:0] out_distance_q, out_distance_d;
  logic              out_done_q, out_done_d;

  // store ports
  logic              occ_we, dist_we, rd_a_en, rd_b_en;
  logic [AW-1:0]     rd_a_addr, vert_addr, ext_addr;
  logic              occ_q;
  logic [DIST_W-1:0] dist_a_q, dist_b_q;
  logic              addr_ok;

  // relax unit
  logic              relax_en;
  logic [DIST_W-1:0] relax_cur, relax_nbr, relax_step, relax_out;

  logic in_fire, out_free, vert_ok, side_ok, last_col, last_row;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ext_addr   = AW'(in_cell_address_i);
  assign addr_ok    = 32'(in_cell_address_i) < 32'(DEPTH);
  assign vert_addr  = bwd_q ? (k_q + AW'(w_eff)) : (k_q - AW'(w_eff));
  assign last_col   = (col_q == w_eff - DIM_W'(1));
  assign last_row   = (row_q == h_eff - DIM_W'(1));
  assign vert_ok    = bwd_q ? !last_row : (row_q != '0);
  assign side_ok    = bwd_q ? !last_col : (col_q != '0);

  gcdt_relax u_relax (
    .en_i   (relax_en),
    .cur_i  (relax_cur),
    .nbr_i  (relax_nbr),
    .step_i (relax_step),
    .dist_o (relax_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q            <= k_d;
    row_q          <= row_d;
    col_q          <= col_d;
    bwd_q          <= bwd_d;
    rd_ok_q        <= rd_ok_d;
    cur_q          <= cur_d;
    side_q         <= side_d;
    diag_q         <= diag_d;
    vert_q         <= vert_d;
    out_distance_q <= out_distance_d;
    out_done_q     <= out_done_d;
  end

  always_comb begin
    state_d        = state_q;
    k_d            = k_q;
    row_d          = row_q;
    col_d          = col_q;
    bwd_d          = bwd_q;
    rd_ok_d        = rd_ok_q;
    cur_d          = cur_q;
    side_d         = side_q;
    diag_d         = diag_q;
    vert_d         = vert_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_distance_d = out_distance_q;
    out_done_d     = out_done_q;
    occ_we         = 1'b0;
    dist_we        = 1'b0;
    rd_a_en        = 1'b0;
    rd_b_en        = 1'b0;
    rd_a_addr      = k_q;
    relax_en       = 1'b0;
    relax_cur      = cur_q;
    relax_nbr      = side_q;
    relax_step     = straight_step_q;

    unique case (state_q)
      ST_IDLE: begin
        rd_a_addr = ext_addr;
        if (in_fire) begin
          if (in_mode_i == MODE_READ) begin
            rd_a_en = 1'b1;
            rd_ok_d = addr_ok;
            state_d = ST_READ;
          end else begin
            occ_we = addr_ok;
            if (in_last_cell_i) begin
              k_d     = '0;
              row_d   = '0;
              col_d   = '0;
              bwd_d   = 1'b0;
              state_d = ST_CELL_RD;
            end
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_distance_d = rd_ok_q ? dist_a_q : DIST_INF;
          out_done_d     = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      ST_CELL_RD: begin
        rd_a_en = 1'b1;
        rd_b_en = vert_ok;
        state_d = ST_CELL_VERT;
      end
      ST_CELL_VERT: begin
        relax_cur = bwd_q ? dist_a_q : (occ_q ? DIST_ZERO : DIST_INF);
        relax_nbr = dist_b_q;
        relax_en  = vert_ok;
        cur_d     = relax_out;
        vert_d    = dist_b_q;
        state_d   = ST_CELL_SIDE;
      end
      ST_CELL_SIDE: begin
        relax_en = side_ok;
        cur_d    = relax_out;
        state_d  = ST_CELL_DIAG;
      end
      ST_CELL_DIAG: begin
        relax_nbr  = diag_q;
        relax_step = diagonal_step_q;
        relax_en   = vert_ok && side_ok;
        dist_we    = 1'b1;
        side_d     = relax_out;
        diag_d     = vert_q;
        state_d    = ST_CELL_RD;
        if (!bwd_q) begin
          if (last_col) begin
            if (last_row) begin
              bwd_d = 1'b1;
            end else begin
              row_d = row_q + DIM_W'(1);
              col_d = '0;
              k_d   = k_q + AW'(1);
            end
          end else begin
            col_d = col_q + DIM_W'(1);
            k_d   = k_q + AW'(1);
          end
        end else begin
          if (col_q == '0) begin
            if (row_q == '0) begin
              state_d = ST_DONE;
            end else begin
              row_d = row_q - DIM_W'(1);
              col_d = w_eff - DIM_W'(1);
              k_d   = k_q - AW'(1);
            end
          end else begin
            col_d = col_q - DIM_W'(1);
            k_d   = k_q - AW'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_distance_d = DIST_ZERO;
          out_done_d     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // occupancy and distance stores
  logic              occ_mem  [DEPTH];
  logic [DIST_W-1:0] dist_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[ext_addr] <= in_occupied_i;
    end
    if (rd_a_en) begin
      occ_q <= occ_mem[rd_a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[k_q] <= relax_out;
    end
    if (rd_a_en) begin
      dist_a_q <= dist_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      dist_b_q <= dist_mem[vert_addr];
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_distance_o       = out_distance_q;
  assign out_transform_done_o = out_done_q;

endmodule

// ----- sv/gcdt_checker.sv -----
// ----------------------------------------------------------------------------
// gcdt_checker
// Port-level checks of the grid chamfer distance transform, bound to the top.
// ----------------------------------------------------------------------------
module gcdt_checker
  import gcdt_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              in_mode_i,
  input logic              in_last_cell_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DIST_W-1:0] out_distance_o,
  input logic              out_transform_done_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // a stalled result beat stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // done beats carry a zero distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_transform_done_o |-> out_distance_o == '0)
    else $error("done beat with nonzero distance");

  // a read or a last load holds off the next input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_mode_i == MODE_READ || in_last_cell_i) |=> in_stall_o)
    else $error("input not stalled after read or last load");

  // a plain load leaves the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_mode_i == MODE_LOAD && !in_last_cell_i |=> !in_stall_o)
    else $error("input stalled after plain load");

endmodule

bind grid_chamfer_distance_transform gcdt_checker u_gcdt_checker (.*);
